@@ hw/rtl/pwm_audio_sample_player_core_assert.svh @@
// Assertion macros for the PWM audio sample player core.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef PWM_AUDIO_SAMPLE_PLAYER_CORE_ASSERT_SVH
`define PWM_AUDIO_SAMPLE_PLAYER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define PASP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pasp: assertion failed");
`define PASP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pasp: assertion failed");
`else
`define PASP_ASSERT(lbl, prop)
`define PASP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/pasp_pkg.sv @@
`timescale 1ns / 1ps
package pasp_pkg;

  // field widths of the item and result channels
  localparam int unsigned OP_W     = 2;
  localparam int unsigned INDEX_W  = 13;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned POS_W    = 13;

  // configuration register widths
  localparam int unsigned PTICKS_W = 20;
  localparam int unsigned SIZE_W   = 14;
  localparam int unsigned PPTR_W   = 13;

  // APB port
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [PTICKS_W-1:0] PTICKS_RST   = 20'd125000;
  localparam logic [SIZE_W-1:0]   BUF_SIZE_RST = 14'd8192;
  localparam logic [SIZE_W-1:0]   PER_SIZE_RST = 14'd1024;
  localparam logic [SIZE_W-1:0]   PTR_LIMIT    = 14'd8192;
  localparam logic [SAMPLE_W-1:0] SAMPLE_FULL  = 8'd255;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_PERIOD_TICKS = 2'd0;
  localparam logic [1:0] REG_BUFFER_SIZE  = 2'd1;
  localparam logic [1:0] REG_PERIOD_SIZE  = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_e;

endpackage

@@ hw/rtl/pwm_audio_sample_player_core.sv @@
// Pipeline: an item passes the stage 1, stage 2 and output registers. Throughput:
// one item per cycle unless results stall; the sample store has one write and one
// read port, and the duty product (sample times period) is registered before it is
// used. Reset: pointers, phase, duty, level and playing clear; configuration
// takes its reset values. The sample store is not cleared and has no clearing pass.
`timescale 1ns / 1ps
`include "pwm_audio_sample_player_core_assert.svh"
module pwm_audio_sample_player_core #(
  parameter int unsigned STORE_DEPTH  = 8192,
  parameter int unsigned PERIOD_WIDTH = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [pasp_pkg::OP_W-1:0]        operation_i,
  input  logic [pasp_pkg::INDEX_W-1:0]     index_i,
  input  logic [pasp_pkg::SAMPLE_W-1:0]    sample_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             pwm_level_o,
  output logic                             period_elapsed_o,
  output logic [pasp_pkg::POS_W-1:0]       play_position_o,
  output logic                             running_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pasp_pkg::APB_AW-1:0]      paddr,
  input  logic [pasp_pkg::APB_DW-1:0]      pwdata,
  output logic [pasp_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);
  import pasp_pkg::*;

  localparam int unsigned AW    = $clog2(STORE_DEPTH);
  localparam int unsigned PW    = PERIOD_WIDTH;
  localparam int unsigned PRODW = PW + SAMPLE_W;
  localparam int unsigned CW    = (AW + 1 > SIZE_W) ? AW + 1 : SIZE_W;

  typedef struct packed {
    logic          play_tick;
    logic          load;
    logic          stop;
    logic          elapsed;
    logic [PW-1:0] phase;
    logic [AW-1:0] pos;
    logic          running;
  } stage_t;

  // ---------------------------------------------------------------- config
  logic [PTICKS_W-1:0] period_ticks_q;
  logic [SIZE_W-1:0]   buffer_size_q;
  logic [SIZE_W-1:0]   period_size_q;
  logic [1:0]          reg_idx;
  logic                cfg_we;

  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_ticks_q <= PTICKS_RST;
      buffer_size_q  <= BUF_SIZE_RST;
      period_size_q  <= PER_SIZE_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_PERIOD_TICKS: period_ticks_q <= pwdata[PTICKS_W-1:0];
        REG_BUFFER_SIZE:  buffer_size_q  <= pwdata[SIZE_W-1:0];
        REG_PERIOD_SIZE:  period_size_q  <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PERIOD_TICKS: prdata = APB_DW'(period_ticks_q);
      REG_BUFFER_SIZE:  prdata = APB_DW'(buffer_size_q);
      REG_PERIOD_SIZE:  prdata = APB_DW'(period_size_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- handshake
  logic   s1_valid_q, s2_valid_q, out_valid_q;
  stage_t s1_q, s2_q, s1_in;
  logic   out_free, s2_free, s1_free, s2_adv, s1_adv, accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s2_adv     = s2_valid_q && out_free;
  assign s2_free    = !s2_valid_q || out_free;
  assign s1_adv     = s1_valid_q && s2_free;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_ready_o = s1_free;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free)  s1_valid_q  <= in_valid_i;
      if (s2_free)  s2_valid_q  <= s1_valid_q;
      if (out_free) out_valid_q <= s2_valid_q;
    end
  end

  // ------------------------------------------- stage 1: pointers and phase
  op_e           op;
  logic [PW-1:0] per;
  logic [PW-1:0] phase_q, phase_d;
  logic [AW-1:0] rp_q, rp_d, rp_adv, raddr;
  logic [PPTR_W-1:0] pp_q, pp_d, pp_adv;
  logic          playing_q, playing_d;
  logic [PW:0]   phase_inc;
  logic          period_end;
  logic [CW-1:0] bsz, rp_inc;
  logic [SIZE_W-1:0] psz, pp_inc;
  logic          pp_wrap;

  assign op         = op_e'(operation_i);
  assign per        = PW'(period_ticks_q);
  assign phase_inc  = (PW + 1)'(phase_q) + (PW + 1)'(1);
  assign period_end = phase_inc >= (PW + 1)'(per);

  // sizes beyond the store saturate
  assign bsz    = (CW'(buffer_size_q) > CW'(STORE_DEPTH)) ? CW'(STORE_DEPTH)
                                                          : CW'(buffer_size_q);
  assign rp_inc = CW'(rp_q) + CW'(1);
  assign rp_adv = (rp_inc >= bsz) ? '0 : rp_inc[AW-1:0];

  assign psz     = (period_size_q > PTR_LIMIT) ? PTR_LIMIT : period_size_q;
  assign pp_inc  = SIZE_W'(pp_q) + SIZE_W'(1);
  assign pp_wrap = pp_inc >= psz;
  assign pp_adv  = pp_wrap ? '0 : pp_inc[PPTR_W-1:0];

  always_comb begin
    s1_in     = '0;
    phase_d   = phase_q;
    rp_d      = rp_q;
    pp_d      = pp_q;
    playing_d = playing_q;
    raddr     = '0;
    unique case (op)
      OP_WRITE: begin
      end
      OP_START: begin
        phase_d   = '0;
        rp_d      = '0;
        pp_d      = '0;
        playing_d = 1'b1;
        s1_in.load = 1'b1;
      end
      OP_STOP: begin
        playing_d  = 1'b0;
        s1_in.stop = 1'b1;
      end
      OP_TICK: begin
        if (playing_q) begin
          s1_in.play_tick = 1'b1;
          s1_in.phase     = phase_q;
          if (period_end) begin
            phase_d       = '0;
            rp_d          = rp_adv;
            raddr         = rp_adv;
            pp_d          = pp_adv;
            s1_in.load    = 1'b1;
            s1_in.elapsed = pp_wrap;
          end else begin
            phase_d = phase_inc[PW-1:0];
          end
        end
      end
      default: ;
    endcase
    s1_in.pos     = rp_d;
    s1_in.running = playing_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      rp_q      <= '0;
      pp_q      <= '0;
      playing_q <= 1'b0;
    end else if (accept) begin
      phase_q   <= phase_d;
      rp_q      <= rp_d;
      pp_q      <= pp_d;
      playing_q <= playing_d;
    end
  end

  // sample store: read data is only refreshed when a reload item enters,
  // so it holds while that item waits in stage 1
  logic [SAMPLE_W-1:0] store_mem [STORE_DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;
  logic [PW-1:0]       s1_per_q;

  always_ff @(posedge clk_i) begin
    if (accept && op == OP_WRITE) store_mem[AW'(index_i)] <= sample_i;
    if (accept && s1_in.load) rdata_q <= store_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q     <= s1_in;
      s1_per_q <= per;
    end
  end

  // ------------------------------------ stage 2: duty product, threshold
  // phase < floor(s*per/255)  <=>  255*(phase+1) <= s*per
  logic [PRODW-1:0] prod_c, thresh_c, s2_prod_q, s2_thresh_q;

  assign prod_c   = s1_q.load ? PRODW'(rdata_q) * PRODW'(s1_per_q) : '0;
  assign thresh_c = PRODW'((PW + 1)'(s1_q.phase) + (PW + 1)'(1)) * PRODW'(SAMPLE_FULL);

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_q        <= s1_q;
      s2_prod_q   <= prod_c;
      s2_thresh_q <= thresh_c;
    end
  end

  // --------------------------------------- stage 3: level and duty state
  logic [PRODW-1:0] duty_q, duty_d;
  logic             level_q, level_d;
  logic             out_elapsed_q, out_running_q;
  logic [AW-1:0]    out_pos_q;

  always_comb begin
    level_d = level_q;
    duty_d  = duty_q;
    if (s2_q.stop) begin
      level_d = 1'b0;
      duty_d  = '0;
    end else begin
      if (s2_q.play_tick) level_d = (s2_thresh_q <= duty_q);
      if (s2_q.load)      duty_d  = s2_prod_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q  <= '0;
      level_q <= 1'b0;
    end else if (s2_adv) begin
      duty_q  <= duty_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_elapsed_q <= s2_q.elapsed;
      out_running_q <= s2_q.running;
      out_pos_q     <= s2_q.pos;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pwm_level_o      = level_q;
  assign period_elapsed_o = out_elapsed_q;
  assign play_position_o  = POS_W'(out_pos_q);
  assign running_o        = out_running_q;

  // ----------------------------------------------------------- checks
  `PASP_ASSERT(a_stopped_low, out_valid_o && !running_o |-> !pwm_level_o)
  `PASP_ASSERT(a_elapsed_running, out_valid_o && period_elapsed_o |-> running_o)
  `PASP_ASSERT_NEXT(a_stop_clears_duty, s2_adv && s2_q.stop, duty_q == '0)
  `PASP_ASSERT(a_full_stall, s1_valid_q && s2_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import pasp_pkg::*;

  localparam int unsigned DEPTH       = 8192;
  localparam int unsigned PTICKS_MASK = (1 << PTICKS_W) - 1;
  localparam int unsigned SIZE_MASK   = (1 << SIZE_W) - 1;

  typedef struct packed {
    logic             level;
    logic             elapsed;
    logic [POS_W-1:0] position;
    logic             running;
  } player_out_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [OP_W-1:0]     operation_i;
  logic [INDEX_W-1:0]  index_i;
  logic [SAMPLE_W-1:0] sample_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                pwm_level_o;
  logic                period_elapsed_o;
  logic [POS_W-1:0]    play_position_o;
  logic                running_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  pwm_audio_sample_player_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .index_i          (index_i),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pwm_level_o      (pwm_level_o),
    .period_elapsed_o (period_elapsed_o),
    .play_position_o  (play_position_o),
    .running_o        (running_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // player mirror
  logic [SAMPLE_W-1:0] m_store   [DEPTH];
  bit                  m_written [DEPTH];
  int unsigned         m_phase, m_duty, m_rp, m_pp;
  bit                  m_playing, m_level;
  int unsigned         cfg_period, cfg_bufsz, cfg_persz;

  player_out_t due_results[$];
  int          errors, checked, elapsed_seen, items_sent, reg_writes;
  bit          no_gaps;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic int unsigned clip_size(int unsigned v);
    return (v > DEPTH) ? DEPTH : v;
  endfunction

  function automatic int unsigned duty_of(int unsigned entry);
    int unsigned s;
    s = m_store[entry % DEPTH];
    return ((s * cfg_period) / SAMPLE_FULL) & PTICKS_MASK;
  endfunction

  // entry the next tick will fetch, or -1 if it does not end a period or playback is stopped
  function automatic int upcoming_read();
    int unsigned bsz;
    if (!m_playing || (m_phase + 1 < cfg_period)) return -1;
    bsz = clip_size(cfg_bufsz);
    return (m_rp + 1 >= bsz) ? 0 : int'(m_rp + 1);
  endfunction

  function automatic player_out_t predict_player(op_e op, logic [INDEX_W-1:0] idx,
                                                 logic [SAMPLE_W-1:0] smp);
    player_out_t r;
    int unsigned nxt;
    r.elapsed = 1'b0;
    case (op)
      OP_WRITE: begin
        m_store[idx]   = smp;
        m_written[idx] = 1'b1;
      end
      OP_START: begin
        m_duty    = duty_of(0);
        m_rp      = 0;
        m_pp      = 0;
        m_phase   = 0;
        m_playing = 1'b1;
      end
      OP_STOP: begin
        m_playing = 1'b0;
        m_duty    = 0;
        m_level   = 1'b0;
      end
      default: begin
        if (m_playing) begin
          nxt     = m_phase + 1;
          m_level = (m_phase < m_duty);
          if (nxt >= cfg_period) begin
            m_phase = 0;
            m_rp    = (m_rp + 1 >= clip_size(cfg_bufsz)) ? 0 : m_rp + 1;
            m_duty  = duty_of(m_rp);
            if (m_pp + 1 >= clip_size(cfg_persz)) begin
              m_pp      = 0;
              r.elapsed = 1'b1;
            end else begin
              m_pp = m_pp + 1;
            end
          end else begin
            m_phase = nxt & PTICKS_MASK;
          end
        end
      end
    endcase
    r.level    = m_level;
    r.position = POS_W'(m_rp);
    r.running  = m_playing;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // valid is left high after acceptance; whoever next advances time lowers it or drives the next item
  task automatic send_item(op_e op, logic [INDEX_W-1:0] idx, logic [SAMPLE_W-1:0] smp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    index_i     <= idx;
    sample_i    <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    due_results.push_back(predict_player(op, idx, smp));
    items_sent++;
  endtask

  task automatic write_sample(int unsigned idx, int unsigned smp);
    send_item(OP_WRITE, INDEX_W'(idx), SAMPLE_W'(smp));
  endtask

  // a fetch of a never-written entry is kept out by filling it just in time
  task automatic play_tick();
    int e;
    e = upcoming_read();
    if (e >= 0 && !m_written[e]) write_sample(e, $urandom_range(0, 255));
    send_item(OP_TICK, INDEX_W'($urandom), SAMPLE_W'($urandom));
  endtask

  task automatic start_play();
    if (!m_written[0]) write_sample(0, $urandom_range(0, 255));
    send_item(OP_START, INDEX_W'($urandom), SAMPLE_W'($urandom));
  endtask

  task automatic stop_play();
    send_item(OP_STOP, INDEX_W'($urandom), SAMPLE_W'($urandom));
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] reg_idx, int unsigned value);
    int unsigned mask;
    wait_results_drained();
    mask = (reg_idx == REG_PERIOD_TICKS) ? PTICKS_MASK : SIZE_MASK;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (reg_idx)
      REG_PERIOD_TICKS: cfg_period = value & PTICKS_MASK;
      REG_BUFFER_SIZE:  cfg_bufsz  = value & SIZE_MASK;
      default:          cfg_persz  = value & SIZE_MASK;
    endcase
    reg_writes++;
    // read it back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== (value & mask)) begin
      errors++;
      if (errors <= 10)
        $display("register %0d read back %0h, expected %0h", reg_idx, prdata, value & mask);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_directed();
    write_sample(0, SAMPLE_FULL);
    write_sample(1, 0);
    write_sample(2, 128);
    write_sample(DEPTH - 1, 1);
    play_tick();                  // stopped: nothing moves
    stop_play();                  // stop while already stopped
    start_play();
    play_tick();
    play_tick();
    start_play();                 // restart mid-playback
    stop_play();
    play_tick();
    write_reg(REG_PERIOD_TICKS, 3);
    write_reg(REG_BUFFER_SIZE, 3);
    write_reg(REG_PERIOD_SIZE, 2);
    start_play();
    repeat (10) play_tick();
  endtask

  task automatic test_config_extremes();
    write_reg(REG_PERIOD_TICKS, 0);
    start_play();
    repeat (4) play_tick();
    write_reg(REG_PERIOD_TICKS, 1);
    repeat (4) play_tick();
    write_reg(REG_PERIOD_TICKS, 2);
    write_reg(REG_BUFFER_SIZE, 0);
    write_reg(REG_PERIOD_SIZE, 0);
    start_play();
    repeat (8) play_tick();
    write_reg(REG_BUFFER_SIZE, 1);
    write_reg(REG_PERIOD_SIZE, 1);
    repeat (6) play_tick();
    write_reg(REG_BUFFER_SIZE, SIZE_MASK);
    write_reg(REG_PERIOD_SIZE, SIZE_MASK);
    start_play();
    repeat (20) play_tick();
    write_reg(REG_BUFFER_SIZE, DEPTH);
    write_reg(REG_PERIOD_SIZE, DEPTH);
    repeat (10) play_tick();
    write_reg(REG_PERIOD_TICKS, PTICKS_MASK);
    start_play();
    repeat (6) play_tick();
    // set a short period, then shrink it below the running phase
    write_reg(REG_PERIOD_TICKS, 40);
    write_reg(REG_BUFFER_SIZE, 5);
    write_reg(REG_PERIOD_SIZE, 3);
    start_play();
    repeat (25) play_tick();
    write_reg(REG_PERIOD_TICKS, 5);
    repeat (8) play_tick();
    stop_play();
  endtask

  task automatic test_random(int target);
    int sent, n, r;
    int unsigned per, bsz, psz, lim;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 75)      per = $urandom_range(2, 12);
      else if (r < 95) per = $urandom_range(13, 300);
      else if (r < 97) per = $urandom_range(0, 1);
      else             per = PTICKS_MASK;
      r = $urandom_range(0, 99);
      if (r < 70)      bsz = $urandom_range(1, 16);
      else if (r < 92) bsz = $urandom_range(17, 200);
      else if (r < 95) bsz = 0;
      else if (r < 98) bsz = DEPTH;
      else             bsz = SIZE_MASK;
      r = $urandom_range(0, 99);
      if (r < 75)      psz = $urandom_range(1, 8);
      else if (r < 85) psz = 0;
      else if (r < 95) psz = $urandom_range(9, 64);
      else             psz = (r < 98) ? DEPTH : SIZE_MASK;
      write_reg(REG_PERIOD_TICKS, per);
      write_reg(REG_BUFFER_SIZE, bsz);
      write_reg(REG_PERIOD_SIZE, psz);
      no_gaps = ($urandom_range(0, 3) == 0);
      lim = (bsz == 0) ? 1 : clip_size(bsz);
      start_play();
      n = $urandom_range(60, 200);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 74) begin
          play_tick();
        end else if (r < 88) begin
          if ($urandom_range(0, 9) < 7) write_sample($urandom_range(0, lim - 1),
                                                     $urandom_range(0, 255));
          else write_sample($urandom_range(0, DEPTH - 1), $urandom_range(0, 255));
        end else if (r < 92) begin
          start_play();
        end else if (r < 96) begin
          stop_play();
        end else if (r < 99) begin
          play_tick();
        end else begin
          wait_results_drained();  // sender holds off until every result is back
        end
        sent++;
      end
    end
    no_gaps = 1'b0;
  endtask

  // result side: stalls of random length, ready stretches short and long in between
  initial begin : ready_gen
    int hold, r;
    bit lvl;
    out_ready_i <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold <= 0) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          lvl  = 1'b1;
          hold = $urandom_range(1, 20);
        end else if (r < 65) begin
          lvl  = 1'b1;
          hold = $urandom_range(50, 200);
        end else if (r < 92) begin
          lvl  = 1'b0;
          hold = $urandom_range(1, 3);
        end else begin
          lvl  = 1'b0;
          hold = $urandom_range(10, 40);
        end
        out_ready_i <= lvl;
      end
      hold--;
    end
  end

  always @(posedge clk_i) begin : result_check
    player_out_t want, got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {pwm_level_o, period_elapsed_o, play_position_o, running_o};
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with nothing outstanding: %p", got);
      end else begin
        want = due_results.pop_front();
        checked++;
        if (got.elapsed === 1'b1) elapsed_seen++;
        if (got.level !== want.level || got.elapsed !== want.elapsed ||
            got.position !== want.position || got.running !== want.running) begin
          errors++;
          if (errors <= 10)
            $display("mismatch at result %0d: level %b/%b elapsed %b/%b pos %0d/%0d run %b/%b",
                     checked, want.level, got.level, want.elapsed, got.elapsed,
                     want.position, got.position, want.running, got.running);
        end
      end
    end
  end

  initial begin : watchdog
    #(30_000_000);
    $display("timeout with %0d results outstanding", due_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : main_seq
    int waited;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    operation_i <= OP_TICK;
    index_i     <= '0;
    sample_i    <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    m_phase     = 0;
    m_duty      = 0;
    m_rp        = 0;
    m_pp        = 0;
    m_playing   = 1'b0;
    m_level     = 1'b0;
    cfg_period  = PTICKS_RST;
    cfg_bufsz   = BUF_SIZE_RST;
    cfg_persz   = PER_SIZE_RST;
    errors      = 0;
    checked     = 0;
    elapsed_seen = 0;
    items_sent  = 0;
    reg_writes  = 0;
    no_gaps     = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_config_extremes();
    test_random(1900);

    in_valid_i <= 1'b0;
    waited = 0;
    while (due_results.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (due_results.size() != 0) begin
      errors += due_results.size();
      $display("%0d results never arrived", due_results.size());
    end

    $display("covered %0d items with %0d register writes: ticks, writes, start and stop",
             items_sent, reg_writes);
    $display("checked %0d results, %0d of them with period elapsed", checked, elapsed_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/pasp_pkg.sv
hw/rtl/pwm_audio_sample_player_core.sv
tb/tb.sv
